@@ rtl/lsc_pkg.sv @@
package lsc_pkg;

  localparam int CW = 16;            // coordinate width
  localparam int DW = CW + 1;        // difference width
  localparam int PW = 2 * DW;        // product width
  localparam int QD = 2;             // depth of the queue between front and back
  localparam int QAW = $clog2(QD);
  localparam int MAX_CLIPS = 8;
  localparam int CLW = $clog2(MAX_CLIPS + 1);

  localparam logic [3:0] CODE_TOP    = 4'b0001;
  localparam logic [3:0] CODE_BOTTOM = 4'b0010;
  localparam logic [3:0] CODE_RIGHT  = 4'b0100;
  localparam logic [3:0] CODE_LEFT   = 4'b1000;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t top;
    coord_t bottom;
  } win_t;

  typedef enum logic [1:0] {
    TRIV_NONE,
    TRIV_ACC,
    TRIV_REJ
  } triv_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    triv_t  triv;
  } item_t;

  typedef struct packed {
    logic   outcome;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } state_t;

  function automatic logic [3:0] outcode(input coord_t x, input coord_t y, input win_t w);
    logic [3:0] c;
    c = 4'b0000;
    if (y < w.top)    c = c | CODE_TOP;
    if (y > w.bottom) c = c | CODE_BOTTOM;
    if (x > w.right)  c = c | CODE_RIGHT;
    if (x < w.left)   c = c | CODE_LEFT;
    return c;
  endfunction

  function automatic logic signed [DW-1:0] sx(input coord_t c);
    return {c[CW-1], c};
  endfunction

endpackage

@@ rtl/lsc_front.sv @@
module lsc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  lsc_pkg::win_t   win,
  input  logic            push,
  output logic            full,
  input  lsc_pkg::coord_t ax,
  input  lsc_pkg::coord_t ay,
  input  lsc_pkg::coord_t bx,
  input  lsc_pkg::coord_t by,
  output logic            q_valid,
  output lsc_pkg::item_t  q_item,
  input  logic            q_pop
);

  lsc_pkg::item_t            ent_r [lsc_pkg::QD];
  logic [lsc_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lsc_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lsc_pkg::QAW:0]     cnt_r, cnt_nxt;
  logic [3:0]                ca, cb;
  lsc_pkg::item_t            item;
  logic                      do_push, do_pop;

  always_comb begin
    ca = lsc_pkg::outcode(ax, ay, win);
    cb = lsc_pkg::outcode(bx, by, win);
    item.ax = ax;
    item.ay = ay;
    item.bx = bx;
    item.by = by;
    if ((ca & cb) != 4'b0000) item.triv = lsc_pkg::TRIV_REJ;
    else if ((ca | cb) == 4'b0000) item.triv = lsc_pkg::TRIV_ACC;
    else item.triv = lsc_pkg::TRIV_NONE;
  end

  assign full    = (cnt_r == (lsc_pkg::QAW+1)'(lsc_pkg::QD));
  assign q_valid = (cnt_r != '0);
  assign q_item  = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (lsc_pkg::QAW+1)'(do_push) - (lsc_pkg::QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= item;
  end

endmodule

@@ rtl/lsc_div.sv @@
module lsc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [lsc_pkg::PW-1:0]   num,
  input  logic [lsc_pkg::DW-1:0]   den,
  output logic                     done,
  output logic [lsc_pkg::PW-1:0]   quo
);

  localparam int CNW = $clog2(lsc_pkg::PW + 1);

  logic [lsc_pkg::PW-1:0] quo_r, quo_nxt;
  logic [lsc_pkg::DW-1:0] rem_r, rem_nxt;
  logic [lsc_pkg::DW-1:0] den_r;
  logic [CNW-1:0]         cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [lsc_pkg::DW:0]   rs;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rs       = {rem_r, quo_r[lsc_pkg::PW-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rs >= {1'b0, den_r}) begin
        rem_nxt = lsc_pkg::DW'(rs - {1'b0, den_r});
        quo_nxt = {quo_r[lsc_pkg::PW-2:0], 1'b1};
      end else begin
        rem_nxt = rs[lsc_pkg::DW-1:0];
        quo_nxt = {quo_r[lsc_pkg::PW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(lsc_pkg::PW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/lsc_clip.sv @@
module lsc_clip (
  input  logic             clk,
  input  logic             rst_n,
  input  lsc_pkg::win_t    win,
  input  logic             q_valid,
  input  lsc_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             res_valid,
  output lsc_pkg::result_t res,
  input  logic             res_ready
);

  localparam int DW = lsc_pkg::DW;
  localparam int PW = lsc_pkg::PW;
  localparam int CW = lsc_pkg::CW;

  lsc_pkg::state_t state_r, state_nxt;

  lsc_pkg::coord_t       ax_r, ay_r, bx_r, by_r;
  lsc_pkg::coord_t       edge_r;
  logic                  vert_r, rej_r, neg_r, negd_r;
  logic [lsc_pkg::CLW-1:0] clips_r;
  logic signed [DW-1:0]  a_r, b_r;
  logic [DW-1:0]         den_r;
  logic signed [PW-1:0]  prod_r;

  logic [3:0]            ca, cb, sca;
  logic                  swap;
  lsc_pkg::coord_t       sax, say, sbx, sby, edge_sel;
  logic                  mv, vert_sel;
  logic                  ev_acc, ev_rej;
  logic signed [DW-1:0]  dx, dy, dother, daxis, dedge;
  logic [PW-1:0]         pmag;
  logic                  div_start, div_done;
  logic [PW-1:0]         div_quo;
  logic signed [DW:0]    qs;
  logic signed [DW:0]    newv;

  // evaluation of the current endpoints
  always_comb begin
    ca   = lsc_pkg::outcode(ax_r, ay_r, win);
    cb   = lsc_pkg::outcode(bx_r, by_r, win);
    swap = (ca == 4'b0000);
    sax  = swap ? bx_r : ax_r;
    say  = swap ? by_r : ay_r;
    sbx  = swap ? ax_r : bx_r;
    sby  = swap ? ay_r : by_r;
    sca  = swap ? cb : ca;
    mv       = 1'b1;
    vert_sel = 1'b1;
    edge_sel = win.top;
    if (((sca & lsc_pkg::CODE_TOP) != 4'b0000) && say != sby) begin
      edge_sel = win.top;
    end else if (((sca & lsc_pkg::CODE_BOTTOM) != 4'b0000) && say != sby) begin
      edge_sel = win.bottom;
    end else if (((sca & lsc_pkg::CODE_RIGHT) != 4'b0000) && sax != sbx) begin
      edge_sel = win.right;
      vert_sel = 1'b0;
    end else if (((sca & lsc_pkg::CODE_LEFT) != 4'b0000) && sax != sbx) begin
      edge_sel = win.left;
      vert_sel = 1'b0;
    end else begin
      mv = 1'b0;
    end
    ev_acc = 1'b0;
    ev_rej = 1'b0;
    if ((ca & cb) != 4'b0000) ev_rej = 1'b1;
    else if ((ca | cb) == 4'b0000) ev_acc = 1'b1;
    else if (clips_r >= lsc_pkg::CLW'(lsc_pkg::MAX_CLIPS)) ev_rej = 1'b1;
    else if (!mv) ev_rej = 1'b1;
    dx     = lsc_pkg::sx(sbx) - lsc_pkg::sx(sax);
    dy     = lsc_pkg::sx(sby) - lsc_pkg::sx(say);
    dother = vert_sel ? dx : dy;
    daxis  = vert_sel ? dy : dx;
    dedge  = lsc_pkg::sx(edge_sel) - (vert_sel ? lsc_pkg::sx(say) : lsc_pkg::sx(sax));
  end

  always_comb begin
    pmag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
    qs   = neg_r ? -$signed(div_quo[DW:0]) : $signed(div_quo[DW:0]);
    newv = qs + (vert_r ? {{2{ax_r[CW-1]}}, ax_r} : {{2{ay_r[CW-1]}}, ay_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsc_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.triv == lsc_pkg::TRIV_NONE) state_nxt = lsc_pkg::ST_EVAL;
          else state_nxt = lsc_pkg::ST_DONE;
        end
      end
      lsc_pkg::ST_EVAL: begin
        if (ev_acc || ev_rej) state_nxt = lsc_pkg::ST_DONE;
        else state_nxt = lsc_pkg::ST_MUL;
      end
      lsc_pkg::ST_MUL:    state_nxt = lsc_pkg::ST_DSTART;
      lsc_pkg::ST_DSTART: state_nxt = lsc_pkg::ST_DIV;
      lsc_pkg::ST_DIV:    if (div_done) state_nxt = lsc_pkg::ST_UPD;
      lsc_pkg::ST_UPD:    state_nxt = lsc_pkg::ST_EVAL;
      lsc_pkg::ST_DONE:   if (res_ready) state_nxt = lsc_pkg::ST_IDLE;
      default:            state_nxt = lsc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = 1'b0;
    div_start  = 1'b0;
    res_valid  = 1'b0;
    unique case (state_r)
      lsc_pkg::ST_IDLE:   q_pop = q_valid;
      lsc_pkg::ST_DSTART: div_start = 1'b1;
      lsc_pkg::ST_DONE:   res_valid = 1'b1;
      default: ;
    endcase
    res.outcome = rej_r;
    res.ax = rej_r ? '0 : ax_r;
    res.ay = rej_r ? '0 : ay_r;
    res.bx = rej_r ? '0 : bx_r;
    res.by = rej_r ? '0 : by_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lsc_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      lsc_pkg::ST_IDLE: begin
        ax_r    <= q_item.ax;
        ay_r    <= q_item.ay;
        bx_r    <= q_item.bx;
        by_r    <= q_item.by;
        rej_r   <= (q_item.triv == lsc_pkg::TRIV_REJ);
        clips_r <= '0;
      end
      lsc_pkg::ST_EVAL: begin
        rej_r  <= ev_rej;
        if (!ev_acc && !ev_rej) begin
          ax_r   <= sax;
          ay_r   <= say;
          bx_r   <= sbx;
          by_r   <= sby;
        end
        a_r    <= dother;
        b_r    <= dedge;
        den_r  <= daxis[DW-1] ? DW'(-daxis) : DW'(daxis);
        negd_r <= daxis[DW-1];
        vert_r <= vert_sel;
        edge_r <= edge_sel;
      end
      lsc_pkg::ST_MUL:    prod_r <= a_r * b_r;
      lsc_pkg::ST_DSTART: neg_r <= prod_r[PW-1] ^ negd_r;
      lsc_pkg::ST_UPD: begin
        if (vert_r) begin
          ax_r <= newv[CW-1:0];
          ay_r <= edge_r;
        end else begin
          ay_r <= newv[CW-1:0];
          ax_r <= edge_r;
        end
        clips_r <= clips_r + 1'b1;
      end
      default: ;
    endcase
  end

  lsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (pmag),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

@@ rtl/line_segment_clipper_top.sv @@
// Cohen-Sutherland clipper for one segment against the window held in four
// registers (left, right, top, bottom; top is the smallest y). A segment that is
// trivially accepted or rejected at entry goes from the input queue straight to
// the done state. Each boundary move of any other segment is evaluate, multiply,
// divider load, the single one-bit-a-cycle restoring divider (34 quotient bits
// and its done cycle) and update; up to eight moves are made. A result waits
// while the output register is still full. Two segments can wait in the input
// queue and one result in the output register. A rejected segment reports
// outcome 1 with all coordinates zero.
module line_segment_clipper_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [lsc_pkg::CW-1:0]   cfg_data,
  input  logic                     push,
  output logic                     full,
  input  logic signed [lsc_pkg::CW-1:0] in_start_x,
  input  logic signed [lsc_pkg::CW-1:0] in_start_y,
  input  logic signed [lsc_pkg::CW-1:0] in_end_x,
  input  logic signed [lsc_pkg::CW-1:0] in_end_y,
  output logic                     empty,
  input  logic                     pop,
  output logic                     out_outcome,
  output logic signed [lsc_pkg::CW-1:0] out_clipped_start_x,
  output logic signed [lsc_pkg::CW-1:0] out_clipped_start_y,
  output logic signed [lsc_pkg::CW-1:0] out_clipped_end_x,
  output logic signed [lsc_pkg::CW-1:0] out_clipped_end_y
);

  lsc_pkg::win_t    win_r;
  lsc_pkg::item_t   q_item;
  logic             q_valid, q_pop;
  logic             res_valid, res_ready;
  lsc_pkg::result_t res, out_r;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= lsc_pkg::CW'(0);
      win_r.right  <= lsc_pkg::CW'(639);
      win_r.top    <= lsc_pkg::CW'(0);
      win_r.bottom <= lsc_pkg::CW'(479);
    end else if (cfg_we) begin
      case (cfg_index)
        lsc_pkg::REG_LEFT:   win_r.left   <= cfg_data;
        lsc_pkg::REG_RIGHT:  win_r.right  <= cfg_data;
        lsc_pkg::REG_TOP:    win_r.top    <= cfg_data;
        lsc_pkg::REG_BOTTOM: win_r.bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  lsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .win     (win_r),
    .push    (push),
    .full    (full),
    .ax      (in_start_x),
    .ay      (in_start_y),
    .bx      (in_end_x),
    .by      (in_end_y),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  lsc_clip u_clip (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && pop) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_r <= res;
  end

  assign empty               = !out_valid_r;
  assign out_outcome         = out_r.outcome;
  assign out_clipped_start_x = out_r.ax;
  assign out_clipped_start_y = out_r.ay;
  assign out_clipped_end_x   = out_r.bx;
  assign out_clipped_end_y   = out_r.by;

endmodule

@@ rtl/lsc_checker.sv @@
module lsc_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic                   out_outcome,
  input logic [lsc_pkg::CW-1:0] out_clipped_start_x,
  input logic [lsc_pkg::CW-1:0] out_clipped_start_y,
  input logic [lsc_pkg::CW-1:0] out_clipped_end_x,
  input logic [lsc_pkg::CW-1:0] out_clipped_end_y
);

  // a waiting result is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_outcome) && $stable(out_clipped_start_x)
      && $stable(out_clipped_end_y)))
    else $error("waiting result changed");

  // rejected segments carry zero coordinates
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_outcome) |-> (out_clipped_start_x == '0 && out_clipped_start_y == '0
      && out_clipped_end_x == '0 && out_clipped_end_y == '0))
    else $error("rejected result with coordinates");

  // only once a reset edge has really been seen
  a_reset: assert property (@(posedge clk)
    ($past(rst_n) === 1'b0) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

bind line_segment_clipper_top lsc_checker u_lsc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .full                (full),
  .empty               (empty),
  .pop                 (pop),
  .out_outcome         (out_outcome),
  .out_clipped_start_x (out_clipped_start_x),
  .out_clipped_start_y (out_clipped_start_y),
  .out_clipped_end_x   (out_clipped_end_x),
  .out_clipped_end_y   (out_clipped_end_y)
);
